// ===== hdl/tscn_pkg.sv =====
// Shared types and constants for the throttle sensor calibrate/normalize block.
package tscn_pkg;

    // Field widths
    localparam int MV_W      = 13;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CAL_W     = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [MV_W-1:0]      mv_t;
    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CAL_W-1:0]     cal_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Operation codes
    localparam func_t FUNC_READ   = 2'd0;
    localparam func_t FUNC_CAPMIN = 2'd1;
    localparam func_t FUNC_CAPMAX = 2'd2;
    localparam func_t FUNC_REINIT = 2'd3;

    // Result status codes
    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_SENSOR = 2'd1;
    localparam status_t STATUS_SPAN   = 2'd2;

    // Calibration levels
    localparam cal_t CAL_NONE = 2'd0;
    localparam cal_t CAL_MIN  = 2'd1;
    localparam cal_t CAL_FULL = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_INIT_MIN   = 3'd0;
    localparam cfg_idx_t REG_INIT_MAX   = 3'd1;
    localparam cfg_idx_t REG_MIN_SPAN   = 3'd2;
    localparam cfg_idx_t REG_VALID_LOW  = 3'd3;
    localparam cfg_idx_t REG_VALID_HIGH = 3'd4;
    localparam cfg_idx_t REG_SLEW_LIMIT = 3'd5;

    // Register reset values
    localparam mv_t RST_INIT_MIN   = 13'd500;
    localparam mv_t RST_INIT_MAX   = 13'd4500;
    localparam mv_t RST_MIN_SPAN   = 13'd300;
    localparam mv_t RST_VALID_LOW  = 13'd100;
    localparam mv_t RST_VALID_HIGH = 13'd4900;
    localparam mv_t RST_SLEW_LIMIT = 13'd500;

    // Q1.12 full scale and the number of quotient bits below it
    localparam mv_t FULL_SCALE = 13'd4096;
    localparam int  DIV_STEPS  = 12;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic prep;
        logic div_step;
        logic finish;
    } tscn_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic exec_short;
        logic prep_short;
        logic div_last;
    } tscn_stat_t;

endpackage

// ===== hdl/tscn_if.sv =====
// Stream interfaces for the sample input and the result output channels.
interface tscn_in_if;
    import tscn_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    mv_t   sample_mv;

    modport source (output valid, output func, output sample_mv, input ready);
    modport sink   (input valid, input func, input sample_mv, output ready);
endinterface

interface tscn_out_if;
    import tscn_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    mv_t     position;
    logic    calibrated;
    mv_t     last_raw_mv;

    modport source (output valid, output status, output position, output calibrated,
                    output last_raw_mv, input ready);
    modport sink   (input valid, input status, input position, input calibrated,
                    input last_raw_mv, output ready);
endinterface

// ===== hdl/tscn_ctrl.sv =====
// Sequencing state machine and output valid flag.
module tscn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tscn_pkg::tscn_stat_t stat,
    output tscn_pkg::tscn_cmd_t  cmd
);
    import tscn_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.exec_short ? ST_FIN : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.prep_short ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold here while the previous result is still unclaimed
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/tscn_datapath.sv =====
// Configuration registers, calibration state, averaging window and span divider.
module tscn_datapath #(
    parameter int WINDOW_TAPS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  tscn_pkg::cfg_idx_t   cfg_index,
    input  tscn_pkg::mv_t        cfg_data,
    input  tscn_pkg::func_t      in_func,
    input  tscn_pkg::mv_t        in_sample,
    input  tscn_pkg::tscn_cmd_t  cmd,
    output tscn_pkg::tscn_stat_t stat,
    output tscn_pkg::status_t    out_status,
    output tscn_pkg::mv_t        out_position,
    output logic                 out_calibrated,
    output tscn_pkg::mv_t        out_last_raw
);
    import tscn_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_TAPS);
    localparam int SUM_W  = MV_W + $clog2(WINDOW_TAPS);
    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_TAPS - 1);
    localparam logic [SUM_W-1:0]  TAPS_W    = SUM_W'(WINDOW_TAPS);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(DIV_STEPS - 1);

    function automatic mv_t abs_diff(input mv_t a, input mv_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration
    mv_t init_min_reg, init_max_reg, min_span_reg;
    mv_t valid_low_reg, valid_high_reg, slew_limit_reg;

    // Calibration and window state
    mv_t               min_mv_reg;
    mv_t               max_mv_reg;
    cal_t              cal_level_reg;
    mv_t               raw_hold_reg;
    mv_t               window_reg [WINDOW_TAPS];
    logic [SLOT_W-1:0] slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    mv_t               last_good_reg;

    // Per-transaction work registers
    func_t                func_reg;
    mv_t                  sample_reg;
    logic [SUM_W-1:0]     base_reg;
    logic [SUM_W-1:0]     den_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    status_t              res_status_reg;
    mv_t                  res_pos_reg;

    // Output payload
    status_t out_status_reg;
    mv_t     out_position_reg;
    logic    out_cal_reg;
    mv_t     out_raw_reg;

    logic                 cap_ok;
    mv_t                  range_mv;
    logic                 span_bad;
    logic                 below_min;
    logic                 above_max;
    logic                 read_full;
    logic                 capmax_span_bad;
    logic                 reinit_span_bad;
    logic [SUM_W-1:0]     sum_upd;
    logic [SUM_W-1:0]     diff;
    logic                 sum_low;
    logic                 over_scale;
    logic [SUM_W:0]       rem_shift;
    logic                 rem_ge;
    logic [SUM_W:0]       rem_sub;
    logic [DIV_STEPS-1:0] quo_next;

    // Operation checks
    assign cap_ok = (sample_reg >= valid_low_reg) && (sample_reg <= valid_high_reg)
                    && (abs_diff(sample_reg, last_good_reg) <= slew_limit_reg);
    assign range_mv  = max_mv_reg - min_mv_reg;
    assign span_bad  = (range_mv < min_span_reg) || (range_mv == '0);
    assign below_min = sample_reg < min_mv_reg;
    assign above_max = sample_reg > max_mv_reg;
    assign read_full = (cal_level_reg == CAL_FULL) && !below_min && !above_max;
    assign capmax_span_bad = abs_diff(sample_reg, min_mv_reg) < min_span_reg;
    assign reinit_span_bad = abs_diff(init_max_reg, init_min_reg) < min_span_reg;
    // running window sum: drop the tap being overwritten, add the new sample
    assign sum_upd = sum_reg - SUM_W'(window_reg[slot_reg]) + SUM_W'(sample_reg);

    // Normalization setup
    assign diff       = sum_reg - base_reg;
    assign sum_low    = sum_reg <= base_reg;
    assign over_scale = diff >= den_reg;

    // One restoring division step
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign quo_next  = {quo_reg[DIV_STEPS-2:0], rem_ge};

    assign stat.exec_short = !((func_reg == FUNC_READ) && read_full && !span_bad);
    assign stat.prep_short = sum_low || over_scale;
    assign stat.div_last   = (cnt_reg == LAST_CNT);

    assign out_status     = out_status_reg;
    assign out_position   = out_position_reg;
    assign out_calibrated = out_cal_reg;
    assign out_last_raw   = out_raw_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_min_reg   <= RST_INIT_MIN;
            init_max_reg   <= RST_INIT_MAX;
            min_span_reg   <= RST_MIN_SPAN;
            valid_low_reg  <= RST_VALID_LOW;
            valid_high_reg <= RST_VALID_HIGH;
            slew_limit_reg <= RST_SLEW_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INIT_MIN:   init_min_reg   <= cfg_data;
                REG_INIT_MAX:   init_max_reg   <= cfg_data;
                REG_MIN_SPAN:   min_span_reg   <= cfg_data;
                REG_VALID_LOW:  valid_low_reg  <= cfg_data;
                REG_VALID_HIGH: valid_high_reg <= cfg_data;
                REG_SLEW_LIMIT: slew_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Calibration state and window update, done in the execute cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg    <= RST_INIT_MIN;
            max_mv_reg    <= RST_INIT_MAX;
            cal_level_reg <= CAL_NONE;
            raw_hold_reg  <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            last_good_reg <= '0;
            for (int i = 0; i < WINDOW_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            case (func_reg)
                FUNC_READ:
                begin
                    raw_hold_reg <= sample_reg;
                    if (read_full)
                    begin
                        window_reg[slot_reg] <= sample_reg;
                        slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                        sum_reg  <= sum_upd;
                    end
                end
                FUNC_CAPMIN:
                begin
                    if (cap_ok)
                    begin
                        last_good_reg <= sample_reg;
                        min_mv_reg    <= sample_reg;
                        cal_level_reg <= CAL_MIN;
                    end
                end
                FUNC_CAPMAX:
                begin
                    if (cap_ok)
                    begin
                        last_good_reg <= sample_reg;
                        max_mv_reg    <= sample_reg;
                        if (!capmax_span_bad)
                        begin
                            cal_level_reg <= CAL_FULL;
                        end
                    end
                end
                FUNC_REINIT:
                begin
                    min_mv_reg    <= init_min_reg;
                    max_mv_reg    <= init_max_reg;
                    cal_level_reg <= CAL_NONE;
                    raw_hold_reg  <= '0;
                    slot_reg      <= '0;
                    sum_reg       <= '0;
                    for (int i = 0; i < WINDOW_TAPS; i++)
                    begin
                        window_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Work registers: operands, divider and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            sample_reg <= in_sample;
        end

        if (cmd.exec)
        begin
            base_reg <= SUM_W'(min_mv_reg) * TAPS_W;
            den_reg  <= SUM_W'(range_mv) * TAPS_W;
            // a calibrated read above max saturates, all other short paths give zero
            res_pos_reg <= ((func_reg == FUNC_READ) && (cal_level_reg == CAL_FULL)
                            && !below_min && above_max) ? FULL_SCALE : '0;
            case (func_reg)
                FUNC_READ:
                begin
                    res_status_reg <= STATUS_OK;
                end
                FUNC_CAPMIN:
                begin
                    res_status_reg <= cap_ok ? STATUS_OK : STATUS_SENSOR;
                end
                FUNC_CAPMAX:
                begin
                    if (!cap_ok)
                    begin
                        res_status_reg <= STATUS_SENSOR;
                    end
                    else
                    begin
                        res_status_reg <= capmax_span_bad ? STATUS_SPAN : STATUS_OK;
                    end
                end
                FUNC_REINIT:
                begin
                    res_status_reg <= reinit_span_bad ? STATUS_SPAN : STATUS_OK;
                end
                default:
                begin
                    res_status_reg <= STATUS_OK;
                end
            endcase
        end

        // window mean at or above max gives full scale, at or below min gives zero
        if (cmd.prep)
        begin
            res_pos_reg <= (!sum_low && over_scale) ? FULL_SCALE : '0;
            rem_reg     <= diff;
            cnt_reg     <= '0;
        end

        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? SUM_W'(rem_sub) : SUM_W'(rem_shift);
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (stat.div_last)
            begin
                res_pos_reg <= MV_W'(quo_next);
            end
        end

        if (cmd.finish)
        begin
            out_status_reg   <= res_status_reg;
            out_position_reg <= res_pos_reg;
            out_cal_reg      <= (cal_level_reg == CAL_FULL);
            out_raw_reg      <= raw_hold_reg;
        end
    end

endmodule

// ===== hdl/throttle_sensor_calibrate_normalize.sv =====
// Top level of the throttle sensor calibrate/normalize block.
//
// Usage:
//   in_ch carries one transaction per operation: func (read position,
//   capture min, capture max, reinitialize) and sample_mv. out_ch returns
//   exactly one result transaction per input: status, position (Q1.12,
//   4096 = full open), calibrated and last_raw_mv.
//   The user must write registers through cfg_we/cfg_index/cfg_data, one
//   per cycle, while no transaction is in flight; the block does not check.
// Sequence:
//   Captures, reinitialize and reads that saturate or are not calibrated
//   skip the divider and go from execute, through setup where needed, to
//   the output load. A read that needs normalization takes execute, setup,
//   12 steps of the restoring divider (one quotient bit per cycle), then
//   the output load. One transaction is processed at a time, so the input
//   accepts again in the cycle after the result is loaded.
// Reset: rst_n clears the state machine, calibration state, the averaging
//   window and loads the register defaults; no result is pending.
// Stall: the result sits in an output register while out_ch.ready is low;
//   a finished transaction waits in its last step until that register frees.
module throttle_sensor_calibrate_normalize #(
    parameter int WINDOW_TAPS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  tscn_pkg::cfg_idx_t cfg_index,
    input  tscn_pkg::mv_t      cfg_data,
    tscn_in_if.sink            in_ch,
    tscn_out_if.source         out_ch
);
    import tscn_pkg::*;

    tscn_cmd_t  cmd;
    tscn_stat_t stat;

    // Sequencer
    tscn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    tscn_datapath #(
        .WINDOW_TAPS (WINDOW_TAPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_func        (in_ch.func),
        .in_sample      (in_ch.sample_mv),
        .cmd            (cmd),
        .stat           (stat),
        .out_status     (out_ch.status),
        .out_position   (out_ch.position),
        .out_calibrated (out_ch.calibrated),
        .out_last_raw   (out_ch.last_raw_mv)
    );

endmodule

// ===== hdl/tscn_checker.sv =====
// Port-level checks for the throttle sensor block, bound to the top level.
module tscn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tscn_pkg::status_t out_status,
    input tscn_pkg::mv_t     out_position,
    input logic              out_calibrated,
    input tscn_pkg::mv_t     out_last_raw
);
    import tscn_pkg::*;

    // one transaction at a time: no acceptance right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_status) && $stable(out_position)
            && $stable(out_calibrated) && $stable(out_last_raw)))
        else $error("result payload changed while stalled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_position <= FULL_SCALE))
        else $error("position above full scale");

    // uncalibrated or failed operations never report an opening
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (!out_calibrated || (out_status != STATUS_OK)))
            |-> (out_position == '0))
        else $error("nonzero position without calibration or with error");

endmodule

bind throttle_sensor_calibrate_normalize tscn_checker u_tscn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_position   (out_ch.position),
    .out_calibrated (out_ch.calibrated),
    .out_last_raw   (out_ch.last_raw_mv)
);

// ===== bench/throttle_sensor_calibrate_normalize_test.sv =====
`timescale 1ns / 100ps
// Testbench for the throttle sensor calibrate/normalize block: directed table, then random phases.
module throttle_sensor_calibrate_normalize_test;
    import tscn_pkg::*;

    localparam int TAPS            = 5;
    localparam int MV_TOP          = 5000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_DIRECTED    = 24;

    // One result transaction as seen on out_ch
    typedef struct packed {
        status_t status;
        mv_t     position;
        logic    calibrated;
        mv_t     last_raw;
    } result_t;

    // One row of the directed table; want is used only when fixed_want is set
    typedef struct packed {
        func_t   func;
        mv_t     sample;
        logic    fixed_want;
        result_t want;
    } op_row_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    mv_t      cfg_data;

    tscn_in_if  in_ch ();
    tscn_out_if out_ch ();

    throttle_sensor_calibrate_normalize #(.WINDOW_TAPS(TAPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Directed operations; rows with fixed_want clear are checked against the predictor
    op_row_t directed_ops [NUM_DIRECTED] = '{
        '{FUNC_READ,   13'd0,    1'b1, '{STATUS_OK,     13'd0,    1'b0, 13'd0}},
        '{FUNC_READ,   13'd5000, 1'b1, '{STATUS_OK,     13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMIN, 13'd4950, 1'b1, '{STATUS_SENSOR, 13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMIN, 13'd50,   1'b1, '{STATUS_SENSOR, 13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMIN, 13'd600,  1'b1, '{STATUS_SENSOR, 13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMIN, 13'd500,  1'b1, '{STATUS_OK,     13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMAX, 13'd700,  1'b1, '{STATUS_SPAN,   13'd0,    1'b0, 13'd5000}},
        '{FUNC_CAPMAX, 13'd1100, 1'b1, '{STATUS_OK,     13'd0,    1'b1, 13'd5000}},
        '{FUNC_READ,   13'd499,  1'b1, '{STATUS_OK,     13'd0,    1'b1, 13'd499}},
        '{FUNC_READ,   13'd1101, 1'b1, '{STATUS_OK,     13'd4096, 1'b1, 13'd1101}},
        '{FUNC_READ,   13'd1100, 1'b0, '0},
        '{FUNC_READ,   13'd1100, 1'b0, '0},
        '{FUNC_READ,   13'd1100, 1'b0, '0},
        '{FUNC_READ,   13'd1100, 1'b0, '0},
        '{FUNC_READ,   13'd1100, 1'b0, '0},
        '{FUNC_READ,   13'd500,  1'b0, '0},
        '{FUNC_READ,   13'd800,  1'b0, '0},
        '{FUNC_CAPMAX, 13'd1700, 1'b1, '{STATUS_SENSOR, 13'd0,    1'b1, 13'd800}},
        '{FUNC_REINIT, 13'd0,    1'b1, '{STATUS_OK,     13'd0,    1'b0, 13'd0}},
        '{FUNC_CAPMIN, 13'd1600, 1'b1, '{STATUS_OK,     13'd0,    1'b0, 13'd0}},
        '{FUNC_CAPMAX, 13'd1200, 1'b1, '{STATUS_OK,     13'd0,    1'b1, 13'd0}},
        '{FUNC_READ,   13'd1599, 1'b1, '{STATUS_OK,     13'd0,    1'b1, 13'd1599}},
        '{FUNC_READ,   13'd1600, 1'b1, '{STATUS_OK,     13'd4096, 1'b1, 13'd1600}},
        '{FUNC_READ,   13'd4096, 1'b1, '{STATUS_OK,     13'd4096, 1'b1, 13'd4096}}
    };

    // Predictor copy of the registers
    int unsigned init_min   = RST_INIT_MIN;
    int unsigned init_max   = RST_INIT_MAX;
    int unsigned span_floor = RST_MIN_SPAN;
    int unsigned valid_low  = RST_VALID_LOW;
    int unsigned valid_high = RST_VALID_HIGH;
    int unsigned slew_limit = RST_SLEW_LIMIT;

    // Predictor copy of the calibration and averaging state
    int unsigned min_mv    = RST_INIT_MIN;
    int unsigned max_mv    = RST_INIT_MAX;
    cal_t        cal_level = CAL_NONE;
    int unsigned raw_hold  = 0;
    int unsigned avg_win [TAPS] = '{default: 0};
    int unsigned win_slot  = 0;
    int unsigned last_good = 0;

    result_t pending_results [$];
    int      fail_count     = 0;
    int      ops_sent       = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    function automatic int unsigned mv_gap(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int clamp_int(int x, int lo, int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Work out the result of one operation and advance the predicted state
    function automatic result_t predict_op(func_t f, mv_t v);
        result_t     r;
        int unsigned s;
        int unsigned acc;
        int unsigned base;
        int unsigned range;
        int unsigned q;
        logic        good;
        int          i;
        r    = '0;
        s    = v;
        good = s >= valid_low && s <= valid_high && mv_gap(s, last_good) <= slew_limit;
        case (f)
            FUNC_READ:
            begin
                raw_hold = s;
                if (cal_level == CAL_FULL && s >= min_mv) begin
                    if (s > max_mv)
                        r.position = FULL_SCALE;
                    else begin
                        avg_win[win_slot] = s;
                        win_slot = (win_slot + 1) % TAPS;
                        acc = 0;
                        for (i = 0; i < TAPS; i++)
                            acc += avg_win[i];
                        range = max_mv - min_mv;
                        base  = min_mv * TAPS;
                        // span too small or zero gives 0, window still updated
                        if (range != 0 && range >= span_floor && acc > base) begin
                            q = ((acc - base) * 4096) / (range * TAPS);
                            r.position = (q > 4096) ? FULL_SCALE : mv_t'(q);
                        end
                    end
                end
            end
            FUNC_CAPMIN:
            begin
                if (!good)
                    r.status = STATUS_SENSOR;
                else begin
                    last_good = s;
                    min_mv    = s;
                    cal_level = CAL_MIN;
                end
            end
            FUNC_CAPMAX:
            begin
                if (!good)
                    r.status = STATUS_SENSOR;
                else begin
                    last_good = s;
                    max_mv    = s;
                    if (mv_gap(max_mv, min_mv) < span_floor)
                        r.status = STATUS_SPAN;
                    else
                        cal_level = CAL_FULL;
                end
            end
            default:
            begin
                // reinitialize keeps the last accepted capture
                min_mv    = init_min;
                max_mv    = init_max;
                cal_level = CAL_NONE;
                raw_hold  = 0;
                avg_win   = '{default: 0};
                win_slot  = 0;
                if (mv_gap(max_mv, min_mv) < span_floor)
                    r.status = STATUS_SPAN;
            end
        endcase
        r.calibrated = (cal_level == CAL_FULL);
        r.last_raw   = mv_t'(raw_hold);
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status %0d position %0d",
                       out_ch.status, out_ch.position);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    fail_count++;
                end
                if (out_ch.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, out_ch.position);
                    fail_count++;
                end
                if (out_ch.calibrated !== want.calibrated) begin
                    $error("calibrated: expected %0d, got %0d",
                           want.calibrated, out_ch.calibrated);
                    fail_count++;
                end
                if (out_ch.last_raw_mv !== want.last_raw) begin
                    $error("last_raw_mv: expected %0d, got %0d",
                           want.last_raw, out_ch.last_raw_mv);
                    fail_count++;
                end
            end
        end
    end

    // Send one transaction; entered and left at a falling edge
    task automatic send_op(func_t f, mv_t v, logic fixed_want, result_t want);
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.sample_mv <= v;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        r = predict_op(f, v);
        pending_results.push_back(fixed_want ? want : r);
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic send(func_t f, int v);
        send_op(f, mv_t'(v), 1'b0, '0);
    endtask

    // Register write; leaves cfg_we high for back-to-back writes
    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= mv_t'(val);
        case (idx)
            REG_INIT_MIN:   init_min   = val;
            REG_INIT_MAX:   init_max   = val;
            REG_MIN_SPAN:   span_floor = val;
            REG_VALID_LOW:  valid_low  = val;
            REG_VALID_HIGH: valid_high = val;
            REG_SLEW_LIMIT: slew_limit = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_regs(int unsigned i_min, int unsigned i_max, int unsigned span,
                            int unsigned v_low, int unsigned v_high, int unsigned slew);
        write_reg(REG_INIT_MIN, i_min);
        write_reg(REG_INIT_MAX, i_max);
        write_reg(REG_MIN_SPAN, span);
        write_reg(REG_VALID_LOW, v_low);
        write_reg(REG_VALID_HIGH, v_high);
        write_reg(REG_SLEW_LIMIT, slew);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and wait until the block has gone idle
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Capture sample that moves toward a target while honoring window and slew
    function automatic int step_toward(int target);
        int lo;
        int hi;
        lo = int'(last_good) - int'(slew_limit);
        hi = int'(last_good) + int'(slew_limit);
        lo = (lo > int'(valid_low)) ? lo : int'(valid_low);
        hi = (hi < int'(valid_high)) ? hi : int'(valid_high);
        if (lo > hi)
            return clamp_int(target, 0, MV_TOP);
        return clamp_int(target, lo, hi);
    endfunction

    task automatic walk_capture(func_t f, int target, int steps);
        int v;
        repeat (steps) begin
            v = step_toward(target);
            send(f, v);
            if (v == target)
                break;
        end
    endtask

    // Position reads mostly around the calibrated range
    task automatic read_burst(int n);
        int lo;
        int hi;
        repeat (n) begin
            lo = clamp_int(int'((min_mv < max_mv) ? min_mv : max_mv) - 150, 0, MV_TOP);
            hi = clamp_int(int'((min_mv > max_mv) ? min_mv : max_mv) + 150, 0, MV_TOP);
            if ($urandom_range(9) < 7)
                send(FUNC_READ, $urandom_range(hi, lo));
            else
                send(FUNC_READ, $urandom_range(MV_TOP, 0));
        end
    endtask

    // Reinitialize now and then, walk both captures, then read
    task automatic calibrate_and_read();
        int lo_target;
        int hi_target;
        int pick;
        if ($urandom_range(3) == 0)
            send(FUNC_REINIT, $urandom_range(MV_TOP, 0));
        lo_target = $urandom_range(valid_high, valid_low);
        walk_capture(FUNC_CAPMIN, lo_target, 10);
        pick = $urandom_range(5);
        if (pick == 0)
            hi_target = int'(min_mv);
        else if (pick == 1)
            hi_target = int'(min_mv) - int'(span_floor) - int'($urandom_range(800, 0));
        else
            hi_target = int'(min_mv) + int'(span_floor) + int'($urandom_range(1500, 0));
        walk_capture(FUNC_CAPMAX, clamp_int(hi_target, 0, MV_TOP), 12);
        read_burst($urandom_range(12, 3));
    endtask

    task automatic run_phase(int p);
        int start;
        int pick;
        quiesce();
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
        case (p)
            0: set_regs(500, 4500, 300, 100, 4900, 500);
            1: set_regs(0, 5000, 0, 0, 5000, 5000);
            2: set_regs(5000, 0, 5000, 0, 5000, 5000);
            3: set_regs(2000, 2100, 1000, 1500, 3500, 100);
            4: set_regs(0, 0, 0, 0, 0, 0);
            6: set_regs(5000, 5000, 5000, 5000, 5000, 0);
            default:
                set_regs($urandom_range(MV_TOP, 0), $urandom_range(MV_TOP, 0),
                         $urandom_range(1500, 0), $urandom_range(1000, 0),
                         $urandom_range(MV_TOP, 4000), $urandom_range(1500, 20));
        endcase
        start = ops_sent;
        while (ops_sent - start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 60)
                calibrate_and_read();
            else if (pick < 85)
                read_burst($urandom_range(8, 2));
            else
                send(func_t'($urandom_range(3)), $urandom_range(MV_TOP, 0));
        end
    endtask

    // Main sequence
    initial
    begin
        int k;
        int p;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_INIT_MIN;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_READ;
        in_ch.sample_mv  = '0;
        out_ch.ready     = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < NUM_DIRECTED; k++)
            send_op(directed_ops[k].func, directed_ops[k].sample,
                    directed_ops[k].fixed_want, directed_ops[k].want);

        for (p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        quiesce();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
